FILE: hdl/ilzd_pkg.sv
// shared types and constants for the inverted lz byte decompressor
`timescale 1ns / 1ps
package ilzd_pkg;

   localparam int WIN_AW = 13;

   // decoded bytes carried by one result transaction
   localparam int OUT_LANES = 4;

   typedef enum logic [3:0] {
      PH_CTRL_A,
      PH_LIT,
      PH_CTRL_B,
      PH_LONG0,
      PH_LONG1,
      PH_LONGX,
      PH_CTRL_C,
      PH_CTRL_D,
      PH_SHORT,
      PH_DONE
   } phase_type;

   // top level sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_PARSE,
      ST_COPY,
      ST_EMIT
   } state_type;

   // control stage to resume the bit walk at
   typedef enum logic [1:0] {
      STG_A,
      STG_B,
      STG_C,
      STG_D
   } stage_type;

endpackage

FILE: hdl/ilzd_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module ilzd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/inverted_lz_byte_decompressor.sv
// Inverted LZ byte decompressor. Each accepted byte is inverted and parsed as
// control, literal or match operand; decoded bytes stream out in groups of up
// to four. A stream start (and reset) first clears the 8 KiB window, one entry
// a cycle; no byte is taken during the clear. A match copies history bytes one
// at a time through the window ram's registered read port: each read is issued,
// then the byte is written back and collected, and a group of four is emitted
// before copying resumes. The end marker gives one result with stream_end and
// length_ok.
`timescale 1ns / 1ps
module inverted_lz_byte_decompressor (
   input  logic        clock,
   input  logic        reset,
   // tdata: in_byte[7:0]; tuser: start_of_stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   // tdata: out_byte_0..out_byte_3, byte_count[2:0], pad to 40 bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   // tuser: stream_end, length_ok
   output logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam int OUT_LANES = ilzd_pkg::OUT_LANES;
   localparam int AW = ilzd_pkg::WIN_AW;
   localparam int CW = $clog2(OUT_LANES + 1);

   ilzd_pkg::state_type state_ff, state_in;
   ilzd_pkg::phase_type phase_ff, phase_in;
   logic [31:0]   explen_ff;
   logic [AW-1:0] wptr_ff, wptr_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [7:0]    cbyte_ff, cbyte_in;
   logic [3:0]    cleft_ff, cleft_in;
   logic [7:0]    fmb_ff, fmb_in;
   logic [8:0]    mlen_ff, mlen_in;
   logic [AW-1:0] mdisp_ff, mdisp_in;
   logic [1:0]    sbits_ff, sbits_in;
   logic [31:0]   dcount_ff, dcount_in;
   logic [7:0]    x_ff, x_in;
   logic          copy_rd_ff, copy_rd_in;
   logic [7:0]    lane_ff [OUT_LANES];
   logic [7:0]    lane_in [OUT_LANES];
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          last_ff, last_in, end_ff, end_in, ok_ff, ok_in;
   logic          pend_start_ff, pend_start_in;
   logic          emit_back_ff, emit_back_in; // 1: return to copy after emit

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;

   // walk result
   ilzd_pkg::phase_type wk_phase;
   logic [7:0] wk_cbyte;
   logic [3:0] wk_cleft;
   logic [1:0] wk_sbits;
   logic       walk_go;
   logic       walk_ctrl; // 1: walk starts on the freshly taken control byte
   ilzd_pkg::stage_type walk_stg;

   ilzd_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_win (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // control bit walk from a given stage until a byte is needed
   always_comb begin
      ilzd_pkg::stage_type stg;
      logic done;
      stg      = walk_stg;
      done     = 1'b0;
      wk_cbyte = walk_ctrl ? x_ff : cbyte_ff;
      wk_cleft = walk_ctrl ? 4'd9 : cleft_ff;
      wk_sbits = sbits_ff;
      wk_phase = phase_ff;
      for (int i = 0; i < 4; i++) begin
         if (!done) begin
            if (wk_cleft <= 4'd1) begin
               done = 1'b1;
               case (stg)
                  ilzd_pkg::STG_A: wk_phase = ilzd_pkg::PH_CTRL_A;
                  ilzd_pkg::STG_B: wk_phase = ilzd_pkg::PH_CTRL_B;
                  ilzd_pkg::STG_C: wk_phase = ilzd_pkg::PH_CTRL_C;
                  default:         wk_phase = ilzd_pkg::PH_CTRL_D;
               endcase
            end else begin
               case (stg)
                  ilzd_pkg::STG_A: begin
                     if (wk_cbyte[0]) begin
                        wk_phase = ilzd_pkg::PH_LIT;
                        done = 1'b1;
                     end
                     stg = ilzd_pkg::STG_B;
                  end
                  ilzd_pkg::STG_B: begin
                     if (wk_cbyte[0]) begin
                        wk_phase = ilzd_pkg::PH_LONG0;
                        done = 1'b1;
                     end
                     stg = ilzd_pkg::STG_C;
                  end
                  ilzd_pkg::STG_C: begin
                     wk_sbits = {wk_cbyte[0], 1'b0};
                     stg = ilzd_pkg::STG_D;
                  end
                  default: begin
                     wk_sbits = {wk_sbits[1], wk_cbyte[0]};
                     wk_phase = ilzd_pkg::PH_SHORT;
                     done = 1'b1;
                  end
               endcase
               wk_cleft = wk_cleft - 4'd1;
               wk_cbyte = {1'b0, wk_cbyte[7:1]};
            end
         end
      end
   end

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      wptr_in       = wptr_ff;
      clr_in        = clr_ff;
      cbyte_in      = cbyte_ff;
      cleft_in      = cleft_ff;
      fmb_in        = fmb_ff;
      mlen_in       = mlen_ff;
      mdisp_in      = mdisp_ff;
      sbits_in      = sbits_ff;
      dcount_in     = dcount_ff;
      x_in          = x_ff;
      copy_rd_in    = copy_rd_ff;
      lane_in       = lane_ff;
      cnt_in        = cnt_ff;
      last_in       = last_ff;
      end_in        = end_ff;
      ok_in         = ok_ff;
      pend_start_in = pend_start_ff;
      emit_back_in  = emit_back_ff;
      walk_go       = 1'b0;
      walk_ctrl     = 1'b0;
      walk_stg      = ilzd_pkg::STG_A;
      wr_en         = 1'b0;
      wr_addr       = clr_ff;
      wr_data       = 8'd0;
      rd_addr       = AW'(wptr_ff + mdisp_ff);
      case (state_ff)
         ilzd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               x_in = ~req_tdata;
               if (req_tuser) begin
                  state_in = ilzd_pkg::ST_CLEAR;
                  clr_in   = '0;
               end else begin
                  state_in = ilzd_pkg::ST_PARSE;
               end
            end
         end
         ilzd_pkg::ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == '1) begin
               wptr_in   = '0;
               cbyte_in  = '0;
               cleft_in  = 4'd1;
               phase_in  = ilzd_pkg::PH_CTRL_A;
               fmb_in    = '0;
               mlen_in   = '0;
               mdisp_in  = '0;
               sbits_in  = '0;
               dcount_in = '0;
               state_in  = pend_start_ff ? ilzd_pkg::ST_IDLE : ilzd_pkg::ST_PARSE;
               pend_start_in = 1'b0;
            end
         end
         ilzd_pkg::ST_PARSE: begin
            state_in = ilzd_pkg::ST_IDLE;
            cnt_in   = '0;
            end_in   = 1'b0;
            ok_in    = 1'b0;
            case (phase_ff)
               ilzd_pkg::PH_CTRL_A, ilzd_pkg::PH_CTRL_B,
               ilzd_pkg::PH_CTRL_C, ilzd_pkg::PH_CTRL_D: begin
                  walk_ctrl = 1'b1;
                  walk_go   = 1'b1;
                  case (phase_ff)
                     ilzd_pkg::PH_CTRL_A: walk_stg = ilzd_pkg::STG_A;
                     ilzd_pkg::PH_CTRL_B: walk_stg = ilzd_pkg::STG_B;
                     ilzd_pkg::PH_CTRL_C: walk_stg = ilzd_pkg::STG_C;
                     default:             walk_stg = ilzd_pkg::STG_D;
                  endcase
               end
               ilzd_pkg::PH_LIT: begin
                  wr_en      = 1'b1;
                  wr_addr    = wptr_ff;
                  wr_data    = x_ff;
                  wptr_in    = wptr_ff + AW'(1);
                  dcount_in  = dcount_ff + 32'd1;
                  lane_in[0] = x_ff;
                  for (int k = 1; k < OUT_LANES; k++) lane_in[k] = 8'd0;
                  cnt_in     = CW'(1);
                  last_in    = 1'b1;
                  emit_back_in = 1'b0;
                  state_in   = ilzd_pkg::ST_EMIT;
                  walk_go    = 1'b1;
               end
               ilzd_pkg::PH_LONG0: begin
                  fmb_in   = x_ff;
                  phase_in = ilzd_pkg::PH_LONG1;
               end
               ilzd_pkg::PH_LONG1: begin
                  if (fmb_ff == 8'd0 && x_ff == 8'd0) begin
                     phase_in = ilzd_pkg::PH_DONE;
                     for (int k = 0; k < OUT_LANES; k++) lane_in[k] = 8'd0;
                     last_in  = 1'b1;
                     end_in   = 1'b1;
                     ok_in    = (dcount_ff == explen_ff);
                     emit_back_in = 1'b0;
                     state_in = ilzd_pkg::ST_EMIT;
                  end else begin
                     mdisp_in = AW'({x_ff, 5'd0} + {8'd0, fmb_ff[7:3]});
                     if (fmb_ff[2:0] == 3'd0) begin
                        phase_in = ilzd_pkg::PH_LONGX;
                     end else begin
                        mlen_in    = 9'(fmb_ff[2:0]) + 9'd2;
                        copy_rd_in = 1'b0;
                        state_in   = ilzd_pkg::ST_COPY;
                     end
                  end
               end
               ilzd_pkg::PH_LONGX: begin
                  mlen_in    = 9'(x_ff) + 9'd1;
                  copy_rd_in = 1'b0;
                  state_in   = ilzd_pkg::ST_COPY;
               end
               ilzd_pkg::PH_SHORT: begin
                  mlen_in    = 9'(sbits_ff) + 9'd2;
                  mdisp_in   = AW'({5'b11111, x_ff});
                  copy_rd_in = 1'b0;
                  state_in   = ilzd_pkg::ST_COPY;
               end
               default: ;
            endcase
            if (walk_go) begin
               cbyte_in = wk_cbyte;
               cleft_in = wk_cleft;
               sbits_in = wk_sbits;
               phase_in = wk_phase;
            end
            if (state_in == ilzd_pkg::ST_COPY) begin
               for (int k = 0; k < OUT_LANES; k++) lane_in[k] = 8'd0;
            end
         end
         ilzd_pkg::ST_COPY: begin
            // one read issued, next cycle the byte is written and collected
            if (!copy_rd_ff) begin
               copy_rd_in = 1'b1;
            end else begin
               copy_rd_in = 1'b0;
               wr_en      = 1'b1;
               wr_addr    = wptr_ff;
               wr_data    = rd_data;
               wptr_in    = wptr_ff + AW'(1);
               dcount_in  = dcount_ff + 32'd1;
               mlen_in    = mlen_ff - 9'd1;
               for (int k = 0; k < OUT_LANES; k++) begin
                  if (CW'(k) == cnt_ff) lane_in[k] = rd_data;
               end
               cnt_in = cnt_ff + CW'(1);
               if (mlen_ff == 9'd1) begin
                  last_in      = 1'b1;
                  emit_back_in = 1'b0;
                  state_in     = ilzd_pkg::ST_EMIT;
                  walk_go      = 1'b1;
                  cbyte_in     = wk_cbyte;
                  cleft_in     = wk_cleft;
                  sbits_in     = wk_sbits;
                  phase_in     = wk_phase;
               end else if (cnt_ff == CW'(OUT_LANES - 1)) begin
                  last_in      = 1'b0;
                  emit_back_in = 1'b1;
                  state_in     = ilzd_pkg::ST_EMIT;
               end
            end
         end
         ilzd_pkg::ST_EMIT: begin
            if (rsp_tready) begin
               cnt_in = '0;
               for (int k = 0; k < OUT_LANES; k++) lane_in[k] = 8'd0;
               state_in = emit_back_ff ? ilzd_pkg::ST_COPY : ilzd_pkg::ST_IDLE;
               copy_rd_in = 1'b0;
            end
         end
         default: state_in = ilzd_pkg::ST_IDLE;
      endcase
   end

   // output decode
   always_comb begin
      req_tready = (state_ff == ilzd_pkg::ST_IDLE) && !pend_start_ff;
      rsp_tvalid = (state_ff == ilzd_pkg::ST_EMIT);
      rsp_tdata  = '0;
      for (int k = 0; k < 4; k++) begin
         if (k < OUT_LANES) rsp_tdata[8*k +: 8] = lane_ff[k];
      end
      rsp_tdata[34:32] = 3'(cnt_ff);
      rsp_tlast  = last_ff;
      rsp_tuser  = {ok_ff, end_ff};
      csr_ready  = 1'b1;
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ilzd_pkg::ST_CLEAR;
         pend_start_ff <= 1'b1;
         clr_ff        <= '0;
         explen_ff     <= '0;
         phase_ff      <= ilzd_pkg::PH_CTRL_A;
         cleft_ff      <= 4'd1;
         cbyte_ff      <= '0;
         wptr_ff       <= '0;
         dcount_ff     <= '0;
         sbits_ff      <= '0;
         copy_rd_ff    <= 1'b0;
         emit_back_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_start_ff <= pend_start_in;
         clr_ff        <= clr_in;
         if (csr_valid) explen_ff <= csr_data;
         phase_ff      <= phase_in;
         cleft_ff      <= cleft_in;
         cbyte_ff      <= cbyte_in;
         wptr_ff       <= wptr_in;
         dcount_ff     <= dcount_in;
         sbits_ff      <= sbits_in;
         copy_rd_ff    <= copy_rd_in;
         emit_back_ff  <= emit_back_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fmb_ff   <= fmb_in;
      mlen_ff  <= mlen_in;
      mdisp_ff <= mdisp_in;
      x_ff     <= x_in;
      lane_ff  <= lane_in;
      cnt_ff   <= cnt_in;
      last_ff  <= last_in;
      end_ff   <= end_in;
      ok_ff    <= ok_in;
   end

endmodule
